[hw/rtl/tmg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmg_pkg
// Types and constants shared by the touch-to-mouse gesture block.
// ----------------------------------------------------------------------------
package tmg_pkg;

  localparam int unsigned POS_W      = 16;
  localparam int unsigned PRES_W     = 10;
  localparam int unsigned TIME_W     = 40;
  localparam int unsigned DELTA_W    = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic OP_TOUCH = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] ACT_DOWN = 2'd0;
  localparam logic [1:0] ACT_UP   = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESHOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_TOLERANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME          = 2'd2;

  localparam logic [POS_W-1:0]  MOVE_THRESHOLD_RST     = 16'd96;
  localparam logic [PRES_W-1:0] PRESSURE_TOLERANCE_RST = 10'd102;
  localparam logic [TIME_W-1:0] HOLD_TIME_RST          = 40'd500000000;

  typedef struct packed {
    logic [POS_W-1:0]  move_threshold;
    logic [PRES_W-1:0] pressure_tolerance;
    logic [TIME_W-1:0] hold_time;
  } cfg_t;

  typedef struct packed {
    logic              opcode;
    logic [1:0]        touch_action;
    logic              pointer_present;
    logic [POS_W-1:0]  x_position;
    logic [POS_W-1:0]  y_position;
    logic [PRES_W-1:0] touch_pressure;
    logic [TIME_W-1:0] elapsed_ns;
    logic              movement_suppressed;
  } item_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic                      axes_valid;
    logic                      left_button;
  } result_t;

endpackage

[hw/rtl/tmg_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmg_engine
// Gesture state and the per-item update: position tracking, move detection,
// hold detection and click generation.
// ----------------------------------------------------------------------------
module tmg_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  tmg_pkg::cfg_t    cfg,
  input  tmg_pkg::item_t   item,
  output tmg_pkg::result_t result
);
  import tmg_pkg::*;

  logic [POS_W-1:0]  cur_x_r, cur_y_r, prev_x_r, prev_y_r;
  logic [POS_W-1:0]  cur_x_nxt, cur_y_nxt, prev_x_nxt, prev_y_nxt;
  logic [PRES_W-1:0] cur_p_r, prev_p_r, cur_p_nxt, prev_p_nxt;
  logic              moved_r, held_r, moved_nxt, held_nxt;

  logic [POS_W-1:0]   adx, ady;
  logic [PRES_W-1:0]  adp;
  logic [DELTA_W-1:0] diff_x, diff_y;
  logic               move_ok, click;

  assign adx = (cur_x_r >= prev_x_r) ? cur_x_r - prev_x_r : prev_x_r - cur_x_r;
  assign ady = (cur_y_r >= prev_y_r) ? cur_y_r - prev_y_r : prev_y_r - cur_y_r;
  assign adp = (cur_p_r >= prev_p_r) ? cur_p_r - prev_p_r : prev_p_r - cur_p_r;
  assign diff_x = {1'b0, cur_x_r} - {1'b0, prev_x_r};
  assign diff_y = {1'b0, cur_y_r} - {1'b0, prev_y_r};
  assign move_ok = ((adx > cfg.move_threshold) || (ady > cfg.move_threshold)) &&
                   (adp <= cfg.pressure_tolerance);

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    cur_p_nxt  = cur_p_r;
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    prev_p_nxt = prev_p_r;
    moved_nxt  = moved_r;
    held_nxt   = held_r;
    click      = 1'b0;
    result     = '0;
    if (item.opcode == OP_TOUCH) begin
      if (item.pointer_present) begin
        cur_x_nxt = item.x_position;
        cur_y_nxt = item.y_position;
        cur_p_nxt = item.touch_pressure;
        if (item.touch_action == ACT_UP) begin
          prev_x_nxt = item.x_position;
          prev_y_nxt = item.y_position;
          prev_p_nxt = item.touch_pressure;
          click      = !moved_r && !held_r;
          held_nxt   = 1'b0;
        end else begin
          if (item.touch_action == ACT_DOWN) begin
            prev_x_nxt = item.x_position;
            prev_y_nxt = item.y_position;
            prev_p_nxt = item.touch_pressure;
            moved_nxt  = 1'b0;
            held_nxt   = 1'b0;
          end
          if (!moved_nxt && !held_nxt && (item.elapsed_ns > cfg.hold_time)) begin
            held_nxt = 1'b1;
          end
        end
      end
      result.left_button = click || held_nxt;
    end else begin
      if (!item.movement_suppressed) begin
        if (moved_r || move_ok) begin
          moved_nxt      = 1'b1;
          result.delta_x = diff_x;
          result.delta_y = diff_y;
        end
        prev_x_nxt        = cur_x_r;
        prev_y_nxt        = cur_y_r;
        result.axes_valid = 1'b1;
      end
      result.left_button = held_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      cur_p_r  <= '0;
      prev_x_r <= '0;
      prev_y_r <= '0;
      prev_p_r <= '0;
      moved_r  <= 1'b0;
      held_r   <= 1'b0;
    end else if (fire) begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      cur_p_r  <= cur_p_nxt;
      prev_x_r <= prev_x_nxt;
      prev_y_r <= prev_y_nxt;
      prev_p_r <= prev_p_nxt;
      moved_r  <= moved_nxt;
      held_r   <= held_nxt;
    end
  end

endmodule

[hw/rtl/touch_to_mouse_gesture.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_to_mouse_gesture
// Single-pointer touch stream to mouse emulation (deltas and left button).
// ----------------------------------------------------------------------------
// Usage: touch events and update ticks enter on the in_ stream, opcode in
// in_tuser. Every item gives exactly one result item on the out_ stream.
// An item is registered at the input, evaluated combinationally against the
// gesture state and lands in the output register, which drives out_tvalid.
// One item is accepted per cycle while the receiver does not stall; the rate
// is set by the single evaluation stage that reads and updates the gesture
// state.
// When the receiver stalls, the output register holds its item and the input
// register still takes one more item; beyond that in_tready drops.
// Reset clears the gesture state, both stage valids and loads the default
// thresholds. The cfg_ port writes one threshold register; it is to be used
// only while no item is in flight, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module touch_to_mouse_gesture (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata from bit 0: touch_action[1:0], pointer_present, x_position[15:0],
  // y_position[15:0], touch_pressure[9:0], elapsed_ns[39:0],
  // movement_suppressed, zero fill.
  input  logic [tmg_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: opcode.
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata from bit 0: delta_x[16:0], delta_y[16:0], axes_valid,
  // left_button, zero fill.
  output logic [tmg_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_we,
  input  logic [tmg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tmg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tmg_pkg::*;

  cfg_t    cfg_r;
  item_t   item_r;
  result_t res_r, res_nxt;
  logic    in_vld_r, out_vld_r;
  logic    advance, fire;

  assign advance    = !out_vld_r || out_tready;
  assign fire       = in_vld_r && advance;
  assign in_tready  = !in_vld_r || advance;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, res_r.left_button, res_r.axes_valid,
                       res_r.delta_y, res_r.delta_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.move_threshold     <= MOVE_THRESHOLD_RST;
      cfg_r.pressure_tolerance <= PRESSURE_TOLERANCE_RST;
      cfg_r.hold_time          <= HOLD_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MOVE_THRESHOLD:     cfg_r.move_threshold     <= cfg_data[POS_W-1:0];
        CFG_PRESSURE_TOLERANCE: cfg_r.pressure_tolerance <= cfg_data[PRES_W-1:0];
        CFG_HOLD_TIME:          cfg_r.hold_time          <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.opcode              <= in_tuser;
      item_r.touch_action        <= in_tdata[1:0];
      item_r.pointer_present     <= in_tdata[2];
      item_r.x_position          <= in_tdata[18:3];
      item_r.y_position          <= in_tdata[34:19];
      item_r.touch_pressure      <= in_tdata[44:35];
      item_r.elapsed_ns          <= in_tdata[84:45];
      item_r.movement_suppressed <= in_tdata[85];
    end
  end

  tmg_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .cfg    (cfg_r),
    .item   (item_r),
    .result (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for the touch-to-mouse gesture block.
// ----------------------------------------------------------------------------
// Touch events and update ticks are streamed into the block in random bursts
// while the result side stalls on its own pattern. A predictor keeps its own
// copy of the gesture state and thresholds and queues one expected result per
// accepted item; every result item is compared field by field against the
// oldest entry. A directed sequence covers the taps, holds, movement and
// pressure corner cases, and random gestures then run under the default,
// extreme and random threshold settings.
// ----------------------------------------------------------------------------
module testbench;
  import tmg_pkg::*;

  localparam logic [1:0] ACT_MOVE  = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  touch_to_mouse_gesture uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted thresholds and gesture state.
  logic [POS_W-1:0]  move_thr;
  logic [PRES_W-1:0] pres_tol;
  logic [TIME_W-1:0] hold_ns;
  logic [POS_W-1:0]  pos_x, pos_y, anchor_x, anchor_y;
  logic [PRES_W-1:0] pres, anchor_pres;
  logic              moved, held;

  result_t pending_results[$];
  int      mismatches = 0;
  int      burst_left = 0;
  int      stall_mode = 0;
  int      stall_len = 0;

  function automatic logic [POS_W-1:0] dist16(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic result_t gesture_step(item_t it);
    result_t r;
    logic    tap;
    r = '0;
    tap = 1'b0;
    if (it.opcode == OP_TOUCH) begin
      if (it.pointer_present) begin
        pos_x = it.x_position;
        pos_y = it.y_position;
        pres = it.touch_pressure;
        if (it.touch_action == ACT_UP) begin
          anchor_x = pos_x;
          anchor_y = pos_y;
          anchor_pres = pres;
          tap = !moved && !held;
          held = 1'b0;
        end else begin
          if (it.touch_action == ACT_DOWN) begin
            anchor_x = pos_x;
            anchor_y = pos_y;
            anchor_pres = pres;
            moved = 1'b0;
            held = 1'b0;
          end
          if (!moved && !held && it.elapsed_ns > hold_ns) held = 1'b1;
        end
      end
      r.left_button = tap | held;
    end else begin
      if (!it.movement_suppressed) begin
        if (!moved && (dist16(pos_x, anchor_x) > move_thr || dist16(pos_y, anchor_y) > move_thr)
            && dist16({6'd0, pres}, {6'd0, anchor_pres}) <= {6'd0, pres_tol}) moved = 1'b1;
        if (moved) begin
          r.delta_x = {1'b0, pos_x} - {1'b0, anchor_x};
          r.delta_y = {1'b0, pos_y} - {1'b0, anchor_y};
        end
        anchor_x = pos_x;
        anchor_y = pos_y;
        r.axes_valid = 1'b1;
      end
      r.left_button = held;
    end
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand40();
    logic [TIME_W-1:0] v;
    v = TIME_W'({$urandom, $urandom});
    return v;
  endfunction

  function automatic item_t touch_item(logic [1:0] act, logic present, logic [POS_W-1:0] x,
                                       logic [POS_W-1:0] y, logic [PRES_W-1:0] p,
                                       logic [TIME_W-1:0] t);
    item_t it;
    it = '0;
    it.opcode = OP_TOUCH;
    it.touch_action = act;
    it.pointer_present = present;
    it.x_position = x;
    it.y_position = y;
    it.touch_pressure = p;
    it.elapsed_ns = t;
    return it;
  endfunction

  function automatic item_t tick_item(logic suppressed);
    item_t it;
    it = '0;
    it.opcode = OP_TICK;
    it.movement_suppressed = suppressed;
    return it;
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it.opcode = 1'($urandom_range(0, 1));
    it.touch_action = 2'($urandom_range(0, 3));
    it.pointer_present = $urandom_range(0, 3) != 0;
    it.x_position = POS_W'($urandom);
    it.y_position = POS_W'($urandom);
    it.touch_pressure = PRES_W'($urandom);
    it.elapsed_ns = rand40();
    it.movement_suppressed = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic int pick_offset(int scale);
    int m;
    case ($urandom_range(0, 3))
      0: m = $urandom_range(0, scale);
      1: m = scale + $urandom_range(0, 2) - 1;
      2: m = $urandom_range(0, 65535);
      default: m = 0;
    endcase
    if (m < 0) m = 0;
    return $urandom_range(0, 1) ? m : -m;
  endfunction

  function automatic logic [TIME_W-1:0] pick_elapsed();
    case ($urandom_range(0, 5))
      0: return hold_ns - 1;
      1: return hold_ns;
      2: return hold_ns + 1;
      3: return rand40();
      4: return rand40() >> $urandom_range(1, 39);
      default: return '0;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 40) $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_item(item_t it);
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, it.movement_suppressed, it.elapsed_ns, it.touch_pressure,
                 it.y_position, it.x_position, it.pointer_present, it.touch_action};
    in_tuser <= it.opcode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(gesture_step(it));
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_MOVE_THRESHOLD:     move_thr = val[POS_W-1:0];
      CFG_PRESSURE_TOLERANCE: pres_tol = val[PRES_W-1:0];
      CFG_HOLD_TIME:          hold_ns = val[TIME_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [POS_W-1:0] thr, logic [PRES_W-1:0] tol,
                                logic [TIME_W-1:0] hold);
    wait_drained();
    write_register(CFG_MOVE_THRESHOLD, CFG_DATA_W'(thr));
    write_register(CFG_PRESSURE_TOLERANCE, CFG_DATA_W'(tol));
    write_register(CFG_HOLD_TIME, hold);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed gestures (down, moves and ticks, up) with some noise.
  task automatic run_gestures(int count);
    int                sent;
    logic [POS_W-1:0]  x, y;
    logic [PRES_W-1:0] p;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(noise_item());
        sent++;
      end else begin
        x = POS_W'($urandom);
        y = POS_W'($urandom);
        p = PRES_W'($urandom);
        send_item(touch_item(ACT_DOWN, 1'b1, x, y, p, pick_elapsed()));
        sent++;
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(0, 2) == 0) begin
            send_item(tick_item($urandom_range(0, 9) == 0));
          end else begin
            x = POS_W'(int'(x) + pick_offset(move_thr));
            y = POS_W'(int'(y) + pick_offset(move_thr));
            p = PRES_W'(int'(p) + pick_offset(pres_tol));
            send_item(touch_item(($urandom_range(0, 3) == 0) ? ACT_SPARE : ACT_MOVE, 1'b1,
                                 x, y, p, pick_elapsed()));
          end
          sent++;
        end
        send_item(tick_item(1'b0));
        sent++;
        if ($urandom_range(0, 4) != 0) begin
          send_item(touch_item(ACT_UP, 1'b1, x, y, p, pick_elapsed()));
          sent++;
        end
      end
    end
  endtask

  task automatic test_directed_cases();
    send_item(tick_item(1'b0));
    send_item(touch_item(ACT_DOWN, 1'b0, 16'hFFFF, 16'hFFFF, 10'h3FF, 40'hFF_FFFF_FFFF));
    send_item(touch_item(ACT_DOWN, 1'b1, 16'd0, 16'd0, 10'd100, 40'd0));
    send_item(touch_item(ACT_MOVE, 1'b1, 16'hFFFF, 16'hFFFF, 10'd100, HOLD_TIME_RST));
    send_item(tick_item(1'b0));
    send_item(touch_item(ACT_MOVE, 1'b1, 16'd0, 16'd0, 10'd100, 40'hFF_FFFF_FFFF));
    send_item(tick_item(1'b0));
    send_item(tick_item(1'b1));
    send_item(touch_item(ACT_UP, 1'b1, 16'd0, 16'd0, 10'd100, 40'd0));
    // Pressure jump just over the tolerance blocks movement.
    send_item(touch_item(ACT_DOWN, 1'b1, 16'd100, 16'd100, 10'd200, 40'd0));
    send_item(touch_item(ACT_MOVE, 1'b1, 16'd197, 16'd100, 10'd303, 40'd0));
    send_item(tick_item(1'b0));
    send_item(touch_item(ACT_SPARE, 1'b1, 16'd197, 16'd100, 10'd303, HOLD_TIME_RST + 1));
    send_item(tick_item(1'b0));
    send_item(touch_item(ACT_UP, 1'b1, 16'd197, 16'd100, 10'd303, 40'd0));
    // A plain tap gives a single click.
    send_item(touch_item(ACT_DOWN, 1'b1, 16'd500, 16'd500, 10'h3FF, 40'd0));
    send_item(touch_item(ACT_UP, 1'b1, 16'd500, 16'd500, 10'h3FF, 40'd0));
    send_item(tick_item(1'b0));
    // A delta equal to the threshold does not count; one past it does.
    send_item(touch_item(ACT_DOWN, 1'b1, 16'd1000, 16'd1000, 10'd0, 40'd0));
    send_item(touch_item(ACT_MOVE, 1'b1, 16'd1096, 16'd1000, 10'd102, 40'd0));
    send_item(tick_item(1'b0));
    send_item(touch_item(ACT_MOVE, 1'b1, 16'd999, 16'd1000, 10'd102, 40'd0));
    send_item(tick_item(1'b0));
    send_item(touch_item(ACT_UP, 1'b1, 16'd999, 16'd1000, 10'd102, 40'd0));
  endtask

  task automatic test_default_settings();
    apply_settings(MOVE_THRESHOLD_RST, PRESSURE_TOLERANCE_RST, HOLD_TIME_RST);
    run_gestures(300);
  endtask

  task automatic test_extreme_settings();
    apply_settings(16'd0, 10'h3FF, 40'd0);
    run_gestures(250);
    apply_settings(16'hFFFF, 10'd0, 40'hFF_FFFF_FFFF);
    run_gestures(250);
  endtask

  task automatic test_random_settings();
    repeat (2) begin
      apply_settings(POS_W'($urandom_range(1, 400)), PRES_W'($urandom_range(0, 200)),
                     rand40() >> 10);
      run_gestures(200);
    end
  endtask

  always @(posedge clk) begin
    if (stall_len == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_len <= $urandom_range(5, 60);
    end else begin
      stall_len <= stall_len - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= $urandom_range(0, 7) != 0;
      default: out_tready <= $urandom_range(0, 7) == 0;
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result item with none expected: %h", out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[16:0] !== want.delta_x)
          report_mismatch($sformatf("delta_x %h, expected %h", out_tdata[16:0], want.delta_x));
        if (out_tdata[33:17] !== want.delta_y)
          report_mismatch($sformatf("delta_y %h, expected %h", out_tdata[33:17], want.delta_y));
        if (out_tdata[34] !== want.axes_valid)
          report_mismatch($sformatf("axes_valid %b, expected %b", out_tdata[34],
                                    want.axes_valid));
        if (out_tdata[35] !== want.left_button)
          report_mismatch($sformatf("left_button %b, expected %b", out_tdata[35],
                                    want.left_button));
      end
    end
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= OP_TOUCH;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MOVE_THRESHOLD;
    cfg_data <= '0;
    move_thr = MOVE_THRESHOLD_RST;
    pres_tol = PRESSURE_TOLERANCE_RST;
    hold_ns = HOLD_TIME_RST;
    pos_x = '0;
    pos_y = '0;
    anchor_x = '0;
    anchor_y = '0;
    pres = '0;
    anchor_pres = '0;
    moved = 1'b0;
    held = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_default_settings();
    test_extreme_settings();
    test_random_settings();

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
